// ----- rtl/tlvw_pkg.sv -----
// ----------------------------------------------------------------------------
// tlvw_pkg
// Types, constants and helpers shared by the TLV template wrapper files.
// ----------------------------------------------------------------------------
package tlvw_pkg;

    localparam int unsigned POS_W      = 10;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned RES_SLOTS  = 6;
    localparam int unsigned CAND_SLOTS = 7;
    localparam int unsigned SLOT_W     = 3;

    localparam logic [POS_W-1:0] MAX_SCRIPT_BYTES = 10'd500;
    localparam logic [POS_W-1:0] OUT_BUFFER_BYTES = 10'd512;
    localparam logic [POS_W-1:0] POS_MAX          = 10'd1023;
    localparam logic [POS_W-1:0] POS_START        = 10'd2;
    localparam logic [POS_W-1:0] LSP_START        = 10'd1;

    localparam logic [4:0]        TAG_2B_MASK  = 5'h1F;
    localparam logic [BYTE_W-1:0] SPLIT_TAG_HI = 8'h9F;
    localparam logic [BYTE_W-1:0] SPLIT_TAG_LO = 8'h18;

    localparam logic [BYTE_W-1:0] TEMPLATE_TAG_RST = 8'd113;
    localparam logic [POS_W-1:0]  MAX_OUT_LEN_RST  = 10'd512;

    // configuration register indexes
    localparam logic CFG_TEMPLATE_TAG = 1'b0;
    localparam logic CFG_MAX_OUT_LEN  = 1'b1;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_TAG2 = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SCRIPT_OVR = 2'd1,
        ST_OUTPUT_OVR = 2'd2,
        ST_TRUNCATED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0]  write_offset;
        logic [BYTE_W-1:0] write_byte;
        logic              is_done;
        logic [1:0]        status;
        logic [POS_W-1:0]  total_length;
        logic              last_result;
    } t_res;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] p,
                                                 input logic [1:0] k);
        logic [POS_W:0] s;
        s = {1'b0, p} + {{(POS_W-1){1'b0}}, k};
        return (s > {1'b0, POS_MAX}) ? POS_MAX : s[POS_W-1:0];
    endfunction

    function automatic t_res write_item(input logic [POS_W-1:0] off,
                                        input logic [BYTE_W-1:0] b);
        t_res r;
        r              = '0;
        r.write_offset = off;
        r.write_byte   = b;
        return r;
    endfunction

endpackage

// ----- rtl/tlvw_in_if.sv -----
// ----------------------------------------------------------------------------
// tlvw_in_if
// Script byte channel: valid, ready and one script byte with its last flag.
// ----------------------------------------------------------------------------
interface tlvw_in_if;
    import tlvw_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] script_byte;
    logic              last;

    modport source (output valid, output script_byte, output last, input ready);
    modport sink   (input valid, input script_byte, input last, output ready);
endinterface

// ----- rtl/tlvw_out_if.sv -----
// ----------------------------------------------------------------------------
// tlvw_out_if
// Result channel: offset-addressed writes and the completion item.
// ----------------------------------------------------------------------------
interface tlvw_out_if;
    import tlvw_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  write_offset;
    logic [BYTE_W-1:0] write_byte;
    logic              is_done;
    logic [1:0]        status;
    logic [POS_W-1:0]  total_length;
    logic              last_result;

    modport source (output valid, output write_offset, output write_byte, output is_done,
                    output status, output total_length, output last_result, input ready);
    modport sink   (input valid, input write_offset, input write_byte, input is_done,
                    input status, input total_length, input last_result, output ready);
endinterface

// ----- rtl/tlv_script_template_wrapper_unit.sv -----
// ----------------------------------------------------------------------------
// tlv_script_template_wrapper_unit
// Parses a TLV script byte stream and wraps it into templates as offset writes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one script byte per request, with last on the final byte.
//   o_out gives offset-addressed writes (data bytes, template tags, length
//   patches) and, after the last byte, one completion item with status and
//   total length. last_result marks the final result of each input request.
//   Configuration (template tag, output length limit) is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// Timing:
//   An accepted byte is parsed in the accept cycle; its results (0 to 5)
//   land in a six-entry result buffer and appear on o_out in the next cycle.
//   The buffer drains one result per cycle while o_out is ready, so a
//   byte with one result sustains one byte per cycle; a byte with more
//   results holds i_in until its last result leaves.
//   i_in.ready is high when the buffer is empty or its last entry leaves.
// Reset and stall:
//   Reset empties the buffer, returns the parser to its start state and
//   loads the register defaults. A stalled o_out holds the current result
//   and stalls i_in while any result is waiting in the buffer.
// ----------------------------------------------------------------------------
module tlv_script_template_wrapper_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [tlvw_pkg::POS_W-1:0]  i_cfg_data,
    tlvw_in_if.sink                     i_in,
    tlvw_out_if.source                  o_out
);
    import tlvw_pkg::*;

    logic [BYTE_W-1:0] r_template_tag;
    logic [POS_W-1:0]  r_max_out_len;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_held, n_held;
    logic [BYTE_W-1:0] r_dr, n_dr;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_lsp, n_lsp;
    logic [BYTE_W-1:0] r_tbc, n_tbc;
    logic [POS_W-1:0]  r_ic, n_ic;
    logic [1:0]        r_err, n_err;

    t_res              r_buf [RES_SLOTS];
    logic [SLOT_W-1:0] r_cnt;

    t_res                  cand [CAND_SLOTS];
    logic [CAND_SLOTS-1:0] cv;
    t_res                  list [CAND_SLOTS];
    logic [SLOT_W-1:0]     n_cnt;
    t_status               st;

    logic in_fire, out_fire;

    assign o_out.valid = (r_cnt != '0);
    assign out_fire    = o_out.valid & o_out.ready;
    assign i_in.ready  = (r_cnt == '0) || ((r_cnt == SLOT_W'(1)) && o_out.ready);
    assign in_fire     = i_in.valid & i_in.ready;

    assign o_out.write_offset = r_buf[0].write_offset;
    assign o_out.write_byte   = r_buf[0].write_byte;
    assign o_out.is_done      = r_buf[0].is_done;
    assign o_out.status       = r_buf[0].status;
    assign o_out.total_length = r_buf[0].total_length;
    assign o_out.last_result  = r_buf[0].last_result;

    // parser step and candidate results in fixed order
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_dr    = r_dr;
        n_pos   = r_pos;
        n_lsp   = r_lsp;
        n_tbc   = r_tbc;
        n_err   = r_err;
        st      = ST_OK;
        cv      = '0;
        for (int k = 0; k < CAND_SLOTS; k++) begin
            cand[k] = '0;
        end

        // template header of a new script
        if (r_ic == '0) begin
            cand[0] = write_item('0, r_template_tag);
            cv[0]   = 1'b1;
        end
        n_ic = (r_ic == POS_MAX) ? r_ic : r_ic + POS_W'(1);
        if (n_ic > MAX_SCRIPT_BYTES) begin
            n_err[0] = 1'b1;
        end

        if (!n_err[0]) begin
            case (r_phase)
                PH_TAG: begin
                    if ((i_in.script_byte[4:0] & TAG_2B_MASK) == TAG_2B_MASK) begin
                        n_held  = i_in.script_byte;
                        n_phase = PH_TAG2;
                    end else begin
                        cand[3] = write_item(n_pos, i_in.script_byte);
                        if (n_pos >= OUT_BUFFER_BYTES) n_err[1] = 1'b1;
                        else                           cv[3] = 1'b1;
                        n_pos   = sat_add(n_pos, 2'd1);
                        n_tbc   = n_tbc + BYTE_W'(1);
                        n_phase = PH_LEN;
                    end
                end
                PH_TAG2: begin
                    // 9f18 after output has begun splits the template
                    if (r_held == SPLIT_TAG_HI && i_in.script_byte == SPLIT_TAG_LO
                        && r_pos > POS_START) begin
                        cand[1] = write_item(r_lsp, r_tbc);
                        if (r_lsp >= OUT_BUFFER_BYTES) n_err[1] = 1'b1;
                        else                           cv[1] = 1'b1;
                        cand[2] = write_item(r_pos, r_template_tag);
                        if (r_pos >= OUT_BUFFER_BYTES) n_err[1] = 1'b1;
                        else                           cv[2] = 1'b1;
                        n_lsp = sat_add(r_pos, 2'd1);
                        n_pos = sat_add(r_pos, 2'd2);
                        n_tbc = '0;
                    end
                    cand[3] = write_item(n_pos, r_held);
                    if (n_pos >= OUT_BUFFER_BYTES) n_err[1] = 1'b1;
                    else                           cv[3] = 1'b1;
                    n_pos   = sat_add(n_pos, 2'd1);
                    cand[4] = write_item(n_pos, i_in.script_byte);
                    if (n_pos >= OUT_BUFFER_BYTES) n_err[1] = 1'b1;
                    else                           cv[4] = 1'b1;
                    n_pos   = sat_add(n_pos, 2'd1);
                    n_tbc   = n_tbc + BYTE_W'(2);
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    cand[3] = write_item(n_pos, i_in.script_byte);
                    if (n_pos >= OUT_BUFFER_BYTES) n_err[1] = 1'b1;
                    else                           cv[3] = 1'b1;
                    n_pos   = sat_add(n_pos, 2'd1);
                    n_tbc   = n_tbc + BYTE_W'(1);
                    n_dr    = i_in.script_byte;
                    n_phase = (i_in.script_byte == '0) ? PH_TAG : PH_DATA;
                end
                default: begin
                    cand[3] = write_item(n_pos, i_in.script_byte);
                    if (n_pos >= OUT_BUFFER_BYTES) n_err[1] = 1'b1;
                    else                           cv[3] = 1'b1;
                    n_pos = sat_add(n_pos, 2'd1);
                    n_tbc = n_tbc + BYTE_W'(1);
                    n_dr  = r_dr - BYTE_W'(1);
                    if (n_dr == '0) n_phase = PH_TAG;
                end
            endcase
        end

        if (i_in.last) begin
            if (n_err[0])                                          st = ST_SCRIPT_OVR;
            else if (n_err[1] || n_pos > r_max_out_len
                     || n_pos > OUT_BUFFER_BYTES)                  st = ST_OUTPUT_OVR;
            else if (n_phase != PH_TAG)                            st = ST_TRUNCATED;
            else                                                   st = ST_OK;
            if (st == ST_OK) begin
                cand[5] = write_item(n_lsp, n_tbc);
                cv[5]   = (n_lsp < OUT_BUFFER_BYTES);
            end
            cand[6]              = '0;
            cand[6].is_done      = 1'b1;
            cand[6].status       = st;
            cand[6].total_length = (st == ST_OK) ? n_pos : '0;
            cv[6]                = 1'b1;
            n_phase = PH_TAG;
            n_held  = '0;
            n_dr    = '0;
            n_pos   = POS_START;
            n_lsp   = LSP_START;
            n_tbc   = '0;
            n_ic    = '0;
            n_err   = '0;
        end
    end

    // pack the valid candidates to the front and flag the final one
    always_comb begin
        n_cnt = '0;
        for (int k = 0; k < CAND_SLOTS; k++) begin
            list[k] = '0;
        end
        for (int k = 0; k < CAND_SLOTS; k++) begin
            if (cv[k]) begin
                list[n_cnt] = cand[k];
                n_cnt       = n_cnt + SLOT_W'(1);
            end
        end
        for (int k = 0; k < CAND_SLOTS; k++) begin
            list[k].last_result = (n_cnt != '0) && (SLOT_W'(k) == n_cnt - SLOT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_template_tag <= TEMPLATE_TAG_RST;
            r_max_out_len  <= MAX_OUT_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMPLATE_TAG: r_template_tag <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_OUT_LEN:  r_max_out_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_held  <= '0;
            r_dr    <= '0;
            r_pos   <= POS_START;
            r_lsp   <= LSP_START;
            r_tbc   <= '0;
            r_ic    <= '0;
            r_err   <= '0;
            r_cnt   <= '0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_dr    <= n_dr;
                r_pos   <= n_pos;
                r_lsp   <= n_lsp;
                r_tbc   <= n_tbc;
                r_ic    <= n_ic;
                r_err   <= n_err;
                r_cnt   <= n_cnt;
            end else if (out_fire) begin
                r_cnt <= r_cnt - SLOT_W'(1);
            end
        end
    end

    // result buffer payload, shifts toward the port as results leave
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < RES_SLOTS; k++) begin
                r_buf[k] <= list[k];
            end
        end else if (out_fire) begin
            for (int k = 0; k < RES_SLOTS - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

endmodule
